[design/cmavg_pkg.sv]
// Shared types, constants and a helper function for the current monitor.
// No dependencies; the files that use this package refer to it by scoped names.
package cmavg_pkg;

    // Sizes of the sample window and of the data paths.
    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int COUNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int CODE_W     = 12;
    localparam int ZERO_W     = 12;
    localparam int SCALE_W    = 20;
    localparam int LEN_W      = 6;
    localparam int SAMPLE_W   = 16;
    localparam int HYST_W     = 15;
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = ((CODE_W > ZERO_W) ? CODE_W : ZERO_W) + 1;
    localparam int PROD_W     = DIFF_W + SCALE_W + 1;
    localparam int QUOT_W     = PROD_W - FRAC_W;
    localparam int TOTAL_W    = SAMPLE_W + SLOT_W + 1;
    localparam int DIV_STEPS  = TOTAL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CMP_W      = SAMPLE_W + 2;
    localparam int FIFO_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_CODE = 3'd0,
        CFG_SCALE     = 3'd1,
        CFG_WIN_LEN   = 3'd2,
        CFG_OVER      = 3'd3,
        CFG_REVERSE   = 3'd4,
        CFG_HYST      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ZERO_W-1:0]          zero_code;
        logic [SCALE_W-1:0]         scale_q16;
        logic [LEN_W-1:0]           win_len;
        logic signed [SAMPLE_W-1:0] over_limit;
        logic signed [SAMPLE_W-1:0] reverse_limit;
        logic [HYST_W-1:0]          hyst_band;
    } t_cfg;

    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_OVER    = 2'd1,
        LVL_REVERSE = 2'd2
    } t_level;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_SAT
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_SUM,
        BK_DIV,
        BK_AVG,
        BK_OUT
    } t_back_state;

    // Window length as used: zero acts as one, anything above the window size
    // acts as the window size.
    function automatic logic [COUNT_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [COUNT_W-1:0] res;
        if (len == '0) begin
            res = COUNT_W'(1);
        end else if (int'(len) > MAX_WINDOW) begin
            res = COUNT_W'(MAX_WINDOW);
        end else begin
            res = COUNT_W'(len);
        end
        return res;
    endfunction

endpackage

[design/current_monitor_avg_hysteresis.sv]
// Top level of the current monitor: configuration registers and the front end,
// queue and back end. Depends on cmavg_pkg, cmavg_front, cmavg_fifo, cmavg_back.
//
// Usage: each request on the input channel (i_adc_valid / o_adc_ready) carries
// one 12-bit converter code. The front end turns it into signed deci-amps
// and drops it into a two-entry queue. The back end updates the
// 32-entry window and its running total, divides the total by the fill count
// with a one-bit-per-cycle restoring divider and runs the hysteresis comparator.
// Each input request gives exactly one result request on the output channel
// (o_res_valid / i_res_ready) with the sample, the average, the window-full
// flag, the level and the level-change event.
// The back end runs a 22-step divider and takes no new sample until its result
// is out; the front end and queue can take up to three more codes meanwhile.
// The result sits in an output register, so a stalled receiver only holds the
// back end; the front end keeps accepting until the queue fills.
// Reset (synchronous, active low) loads the register defaults, empties the
// window and puts the comparator in the normal level. Writing the window length
// through the configuration port empties the window and keeps the level.
module current_monitor_avg_hysteresis (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [cmavg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cmavg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                    i_adc_valid,
    output logic                                    o_adc_ready,
    input  logic [cmavg_pkg::CODE_W-1:0]            i_adc_code,
    output logic                                    o_res_valid,
    input  logic                                    i_res_ready,
    output logic signed [cmavg_pkg::SAMPLE_W-1:0]   o_sample_current,
    output logic signed [cmavg_pkg::SAMPLE_W-1:0]   o_average_current,
    output logic                                    o_window_ready,
    output logic [1:0]                              o_level_state,
    output logic                                    o_state_changed
);

    cmavg_pkg::t_cfg r_cfg;

    logic                                  w_clear;
    logic                                  w_push;
    logic signed [cmavg_pkg::SAMPLE_W-1:0] w_push_data;
    logic                                  w_full;
    logic                                  w_pop;
    logic signed [cmavg_pkg::SAMPLE_W-1:0] w_pop_data;
    logic                                  w_empty;

    // A write of the window length also clears the window in the back end.
    assign w_clear = i_cfg_we && (i_cfg_index == cmavg_pkg::CFG_WIN_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_code     <= cmavg_pkg::ZERO_W'(2048);
            r_cfg.scale_q16     <= cmavg_pkg::SCALE_W'(80019);
            r_cfg.win_len       <= cmavg_pkg::LEN_W'(32);
            r_cfg.over_limit    <= cmavg_pkg::SAMPLE_W'(1500);
            r_cfg.reverse_limit <= cmavg_pkg::SAMPLE_W'(-1500);
            r_cfg.hyst_band     <= cmavg_pkg::HYST_W'(50);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cmavg_pkg::CFG_ZERO_CODE: r_cfg.zero_code  <= i_cfg_data[cmavg_pkg::ZERO_W-1:0];
                cmavg_pkg::CFG_SCALE:     r_cfg.scale_q16  <= i_cfg_data[cmavg_pkg::SCALE_W-1:0];
                cmavg_pkg::CFG_WIN_LEN:   r_cfg.win_len    <= i_cfg_data[cmavg_pkg::LEN_W-1:0];
                cmavg_pkg::CFG_OVER:      r_cfg.over_limit <= i_cfg_data[cmavg_pkg::SAMPLE_W-1:0];
                cmavg_pkg::CFG_REVERSE: begin
                    r_cfg.reverse_limit <= i_cfg_data[cmavg_pkg::SAMPLE_W-1:0];
                end
                cmavg_pkg::CFG_HYST:      r_cfg.hyst_band  <= i_cfg_data[cmavg_pkg::HYST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cmavg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_adc_valid),
        .o_ready (o_adc_ready),
        .i_code  (i_adc_code),
        .o_push  (w_push),
        .o_sample(w_push_data),
        .i_full  (w_full)
    );

    cmavg_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_data),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_data (w_pop_data),
        .o_empty(w_empty)
    );

    cmavg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_clear          (w_clear),
        .i_empty          (w_empty),
        .i_data           (w_pop_data),
        .o_pop            (w_pop),
        .o_valid          (o_res_valid),
        .i_ready          (i_res_ready),
        .o_sample_current (o_sample_current),
        .o_average_current(o_average_current),
        .o_window_ready   (o_window_ready),
        .o_level_state    (o_level_state),
        .o_state_changed  (o_state_changed)
    );

endmodule

[design/cmavg_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cmavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/cmavg_front.sv]
// Front end: accepts converter codes and turns them into saturated deci-amps.
// Depends on cmavg_pkg.
module cmavg_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cmavg_pkg::t_cfg                      i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [cmavg_pkg::CODE_W-1:0]         i_code,
    output logic                                 o_push,
    output logic signed [cmavg_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                                 i_full
);

    localparam int DIFF_W   = cmavg_pkg::DIFF_W;
    localparam int PROD_W   = cmavg_pkg::PROD_W;
    localparam int QUOT_W   = cmavg_pkg::QUOT_W;
    localparam int SAMPLE_W = cmavg_pkg::SAMPLE_W;

    cmavg_pkg::t_front_state r_state, n_state;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_diff_x;
    logic signed [PROD_W-1:0] w_scale_x;
    logic signed [QUOT_W-1:0] w_quot;
    logic signed [QUOT_W-1:0] w_max;
    logic signed [QUOT_W-1:0] w_min;

    assign w_diff = $signed(DIFF_W'(i_code)) - $signed(DIFF_W'(i_cfg.zero_code));
    assign w_diff_x  = {{(PROD_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
    assign w_scale_x = $signed(PROD_W'(i_cfg.scale_q16));

    // The arithmetic shift rounds toward minus infinity, then saturate.
    assign w_quot = QUOT_W'(r_prod >>> cmavg_pkg::FRAC_W);
    assign w_max  = {{(QUOT_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    assign w_min  = {{(QUOT_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    always_comb begin
        if (w_quot > w_max) begin
            o_sample = SAMPLE_W'(w_max);
        end else if (w_quot < w_min) begin
            o_sample = SAMPLE_W'(w_min);
        end else begin
            o_sample = SAMPLE_W'(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmavg_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_diff <= w_diff;
        end
        if (r_state == cmavg_pkg::FR_MUL) begin
            r_prod <= w_diff_x * w_scale_x;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            cmavg_pkg::FR_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = cmavg_pkg::FR_MUL;
                end
            end
            cmavg_pkg::FR_MUL: begin
                n_state = cmavg_pkg::FR_SAT;
            end
            cmavg_pkg::FR_SAT: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = cmavg_pkg::FR_IDLE;
                end
            end
            default: begin
                n_state = cmavg_pkg::FR_IDLE;
            end
        endcase
    end

endmodule

[design/cmavg_fifo.sv]
// Short queue of converted samples between the front and back ends.
// Depends on cmavg_pkg.
module cmavg_fifo (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic signed [cmavg_pkg::SAMPLE_W-1:0] i_data,
    output logic                                  o_full,
    input  logic                                  i_pop,
    output logic signed [cmavg_pkg::SAMPLE_W-1:0] o_data,
    output logic                                  o_empty
);

    localparam int DEPTH = cmavg_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [cmavg_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/cmavg_back.sv]
// Back end: sample window, running total, iterative average and the
// hysteresis comparator, with the result register. Depends on cmavg_pkg
// and cmavg_ram.
module cmavg_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cmavg_pkg::t_cfg                       i_cfg,
    input  logic                                  i_clear,
    input  logic                                  i_empty,
    input  logic signed [cmavg_pkg::SAMPLE_W-1:0] i_data,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [cmavg_pkg::SAMPLE_W-1:0] o_sample_current,
    output logic signed [cmavg_pkg::SAMPLE_W-1:0] o_average_current,
    output logic                                  o_window_ready,
    output logic [1:0]                            o_level_state,
    output logic                                  o_state_changed
);

    localparam int SAMPLE_W = cmavg_pkg::SAMPLE_W;
    localparam int SLOT_W   = cmavg_pkg::SLOT_W;
    localparam int COUNT_W  = cmavg_pkg::COUNT_W;
    localparam int TOTAL_W  = cmavg_pkg::TOTAL_W;
    localparam int STEP_W   = cmavg_pkg::STEP_W;
    localparam int CMP_W    = cmavg_pkg::CMP_W;

    cmavg_pkg::t_back_state r_state, n_state;
    cmavg_pkg::t_level      r_level, n_level;

    logic [SLOT_W-1:0]          r_slot;
    logic [COUNT_W-1:0]         r_filled;
    logic signed [TOTAL_W-1:0]  r_total;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic [COUNT_W-1:0]         r_rem;
    logic [TOTAL_W-1:0]         r_quo;
    logic                       r_neg;
    logic [STEP_W-1:0]          r_step;
    logic                       r_full;
    logic signed [SAMPLE_W-1:0] r_avg;
    logic                       r_out_valid;

    logic [COUNT_W-1:0]         w_len;
    logic                       w_was_full;
    logic signed [SAMPLE_W-1:0] w_old;
    logic [COUNT_W:0]           w_rem_sh;
    logic                       w_bit;
    logic [TOTAL_W-1:0]         w_quo_signed;
    logic                       w_load_out;
    logic signed [CMP_W-1:0]    w_avg_x;
    logic signed [CMP_W-1:0]    w_over_x;
    logic signed [CMP_W-1:0]    w_rev_x;
    logic signed [CMP_W-1:0]    w_hyst_x;

    assign w_len      = cmavg_pkg::eff_length(i_cfg.win_len);
    assign w_was_full = (r_filled >= w_len);

    cmavg_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(cmavg_pkg::MAX_WINDOW)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (r_state == cmavg_pkg::BK_READ),
        .i_waddr(r_slot),
        .i_wdata(r_cur),
        .i_raddr(r_slot),
        .o_rdata(w_old)
    );

    // One restoring division step on the magnitude of the total.
    assign w_rem_sh     = {r_rem, r_quo[TOTAL_W-1]};
    assign w_bit        = (w_rem_sh >= {1'b0, r_filled});
    assign w_quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    assign w_avg_x  = CMP_W'(r_avg);
    assign w_over_x = CMP_W'(i_cfg.over_limit);
    assign w_rev_x  = CMP_W'(i_cfg.reverse_limit);
    assign w_hyst_x = $signed(CMP_W'(i_cfg.hyst_band));

    always_comb begin
        n_level = r_level;
        if (r_full) begin
            unique case (r_level)
                cmavg_pkg::LVL_NORMAL: begin
                    if (w_avg_x >= w_over_x) begin
                        n_level = cmavg_pkg::LVL_OVER;
                    end else if (w_avg_x <= w_rev_x) begin
                        n_level = cmavg_pkg::LVL_REVERSE;
                    end
                end
                cmavg_pkg::LVL_OVER: begin
                    if (w_avg_x <= w_over_x - w_hyst_x) begin
                        n_level = cmavg_pkg::LVL_NORMAL;
                    end
                end
                cmavg_pkg::LVL_REVERSE: begin
                    if (w_avg_x >= w_rev_x + w_hyst_x) begin
                        n_level = cmavg_pkg::LVL_NORMAL;
                    end
                end
                default: begin
                    n_level = cmavg_pkg::LVL_NORMAL;
                end
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            cmavg_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = cmavg_pkg::BK_READ;
                end
            end
            cmavg_pkg::BK_READ: begin
                n_state = cmavg_pkg::BK_SUM;
            end
            cmavg_pkg::BK_SUM: begin
                n_state = cmavg_pkg::BK_DIV;
            end
            cmavg_pkg::BK_DIV: begin
                if (int'(r_step) == cmavg_pkg::DIV_STEPS - 1) begin
                    n_state = cmavg_pkg::BK_AVG;
                end
            end
            cmavg_pkg::BK_AVG: begin
                n_state = cmavg_pkg::BK_OUT;
            end
            cmavg_pkg::BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = cmavg_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = cmavg_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmavg_pkg::BK_IDLE;
            r_level     <= cmavg_pkg::LVL_NORMAL;
            r_slot      <= '0;
            r_filled    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_slot   <= '0;
                r_filled <= '0;
                r_total  <= '0;
            end else if (r_state == cmavg_pkg::BK_READ) begin
                // The old entry leaves the total only once the window is full.
                if (w_was_full) begin
                    r_total <= r_total - TOTAL_W'(w_old) + TOTAL_W'(r_cur);
                end else begin
                    r_total  <= r_total + TOTAL_W'(r_cur);
                    r_filled <= r_filled + 1'b1;
                end
                r_slot <= (COUNT_W'(r_slot) + 1'b1 == w_len) ? '0 : r_slot + 1'b1;
            end
            if (w_load_out) begin
                r_level     <= n_level;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_data;
        end
        unique case (r_state)
            cmavg_pkg::BK_SUM: begin
                r_full <= w_was_full;
                r_neg  <= r_total[TOTAL_W-1];
                r_quo  <= r_total[TOTAL_W-1] ? TOTAL_W'(-r_total) : TOTAL_W'(r_total);
                r_rem  <= '0;
                r_step <= '0;
            end
            cmavg_pkg::BK_DIV: begin
                r_rem  <= w_bit ? COUNT_W'(w_rem_sh - {1'b0, r_filled}) : COUNT_W'(w_rem_sh);
                r_quo  <= {r_quo[TOTAL_W-2:0], w_bit};
                r_step <= r_step + 1'b1;
            end
            cmavg_pkg::BK_AVG: begin
                r_avg <= SAMPLE_W'(w_quo_signed);
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            o_sample_current  <= r_cur;
            o_average_current <= r_avg;
            o_window_ready    <= r_full;
            o_level_state     <= n_level;
            o_state_changed   <= (n_level != r_level);
        end
    end

    assign o_valid = r_out_valid;

endmodule

[verif/tb_current_monitor_avg_hysteresis.sv]
`timescale 1ns / 100ps
// Self-checking testbench for current_monitor_avg_hysteresis. It sends directed
// and random converter codes and checks every result against an in-line model.
// Depends on cmavg_pkg and on the design sources of the current monitor.
module tb_current_monitor_avg_hysteresis;

    localparam int ITEM_TARGET    = 1850;
    localparam int GAP_MAX        = 18;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 50;

    localparam int SAMPLE_W   = cmavg_pkg::SAMPLE_W;
    localparam int CFG_IDX_W  = cmavg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = cmavg_pkg::CFG_DATA_W;
    localparam int CODE_W     = cmavg_pkg::CODE_W;
    localparam int ZERO_W     = cmavg_pkg::ZERO_W;
    localparam int SCALE_W    = cmavg_pkg::SCALE_W;
    localparam int LEN_W      = cmavg_pkg::LEN_W;
    localparam int HYST_W     = cmavg_pkg::HYST_W;
    localparam int FRAC_W     = cmavg_pkg::FRAC_W;
    localparam int MAX_WINDOW = cmavg_pkg::MAX_WINDOW;

    // One expected result, in the widths the block drives.
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] average;
        logic                       full;
        cmavg_pkg::t_level          level;
        logic                       changed;
    } t_reading;

    // Every input starts at a known value, reset included.
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                       i_adc_valid = 1'b0;
    logic [CODE_W-1:0]          i_adc_code  = '0;
    logic                       i_res_ready = 1'b0;
    logic                       o_adc_ready;
    logic                       o_res_valid;
    logic signed [SAMPLE_W-1:0] o_sample_current;
    logic signed [SAMPLE_W-1:0] o_average_current;
    logic                       o_window_ready;
    logic [1:0]                 o_level_state;
    logic                       o_state_changed;

    // Model copy of the configuration registers.
    logic [ZERO_W-1:0]          cfg_zero;
    logic [SCALE_W-1:0]         cfg_scale;
    logic [LEN_W-1:0]           cfg_len;
    logic signed [SAMPLE_W-1:0] cfg_over;
    logic signed [SAMPLE_W-1:0] cfg_reverse;
    logic [HYST_W-1:0]          cfg_band;

    // Model copy of the window and the comparator.
    int                win_samples [MAX_WINDOW];
    int                win_next;
    int                win_count;
    int                win_sum;
    cmavg_pkg::t_level cur_level;

    t_reading pending_readings [$];

    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int level_changes   = 0;
    int phases_run      = 0;
    int quiet_cycles    = 0;
    bit gaps_enabled    = 1'b1;

    current_monitor_avg_hysteresis u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_adc_valid       (i_adc_valid),
        .o_adc_ready       (o_adc_ready),
        .i_adc_code        (i_adc_code),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_sample_current  (o_sample_current),
        .o_average_current (o_average_current),
        .o_window_ready    (o_window_ready),
        .o_level_state     (o_level_state),
        .o_state_changed   (o_state_changed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Emptying the window leaves the comparator level alone.
    function automatic void clear_window_model();
        win_next  = 0;
        win_count = 0;
        win_sum   = 0;
    endfunction

    // Works out the result of one accepted code and advances the model state.
    function automatic t_reading predict_reading(input logic [CODE_W-1:0] code);
        t_reading          r;
        longint            scaled;
        int                len;
        int                slot;
        int                cur;
        int                avg;
        int                over_i;
        int                rev_i;
        int                band_i;
        cmavg_pkg::t_level prior;
        // A length of zero behaves as one, anything past the window size as the size.
        if (cfg_len == '0) begin
            len = 1;
        end else if (int'(cfg_len) > MAX_WINDOW) begin
            len = MAX_WINDOW;
        end else begin
            len = int'(cfg_len);
        end
        // The arithmetic shift floors, so negative currents round toward minus infinity.
        scaled = ((longint'(code) - longint'(cfg_zero)) * longint'(cfg_scale)) >>> FRAC_W;
        if (scaled > 32767) begin
            cur = 32767;
        end else if (scaled < -32768) begin
            cur = -32768;
        end else begin
            cur = int'(scaled);
        end
        // Once full, the oldest entry leaves the running total as the new one enters.
        slot = win_next % len;
        if (win_count >= len) begin
            win_sum -= win_samples[slot];
        end else begin
            win_count++;
        end
        win_samples[slot] = cur;
        win_sum += cur;
        win_next = (slot + 1) % len;
        avg = win_sum / win_count;
        // The comparator only moves once the window is full; limits are widened
        // to 32 bits so that the release levels cannot overflow.
        prior  = cur_level;
        over_i = cfg_over;
        rev_i  = cfg_reverse;
        band_i = cfg_band;
        if (win_count >= len) begin
            case (cur_level)
                cmavg_pkg::LVL_NORMAL: begin
                    if (avg >= over_i) begin
                        cur_level = cmavg_pkg::LVL_OVER;
                    end else if (avg <= rev_i) begin
                        cur_level = cmavg_pkg::LVL_REVERSE;
                    end
                end
                cmavg_pkg::LVL_OVER: begin
                    if (avg <= over_i - band_i) begin
                        cur_level = cmavg_pkg::LVL_NORMAL;
                    end
                end
                default: begin
                    if (avg >= rev_i + band_i) begin
                        cur_level = cmavg_pkg::LVL_NORMAL;
                    end
                end
            endcase
        end
        r.sample  = SAMPLE_W'(cur);
        r.average = SAMPLE_W'(avg);
        r.full    = (win_count >= len);
        r.level   = cur_level;
        r.changed = (cur_level != prior);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
                     $time, field, results_checked, got, want);
        end
        mismatch_count++;
    endtask

    // A register write lowers the enable again at the clock edge that takes the write and
    // waits for the clock before it returns, so the enable never gets two assignments in the same time step.
    task automatic write_register(input cmavg_pkg::t_cfg_idx index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            cmavg_pkg::CFG_ZERO_CODE: begin
                cfg_zero = data[ZERO_W-1:0];
            end
            cmavg_pkg::CFG_SCALE: begin
                cfg_scale = data[SCALE_W-1:0];
            end
            cmavg_pkg::CFG_WIN_LEN: begin
                cfg_len = data[LEN_W-1:0];
                clear_window_model();
            end
            cmavg_pkg::CFG_OVER: begin
                cfg_over = data[SAMPLE_W-1:0];
            end
            cmavg_pkg::CFG_REVERSE: begin
                cfg_reverse = data[SAMPLE_W-1:0];
            end
            cmavg_pkg::CFG_HYST: begin
                cfg_band = data[HYST_W-1:0];
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // Sends one code as a request. When no gap is drawn, valid simply stays high
    // and only the payload changes, so back-to-back requests keep it asserted.
    task automatic send_code(input logic [CODE_W-1:0] code);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            i_adc_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_adc_valid <= 1'b1;
        i_adc_code  <= code;
        do @(posedge i_clk); while (o_adc_ready !== 1'b1);
        pending_readings.push_back(predict_reading(code));
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has been returned; the
    // block is idle afterwards, so registers may be written.
    task automatic hold_until_drained();
        i_adc_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // Conversion at the code extremes, then saturation both ways and a zero scale.
    task automatic test_conversion_extremes();
        send_code(12'd0);
        send_code(12'd4095);
        send_code(12'd2048);
        send_code(12'd2047);
        hold_until_drained();
        write_register(cmavg_pkg::CFG_ZERO_CODE, 20'd0);
        write_register(cmavg_pkg::CFG_SCALE, 20'hFFFFF);
        send_code(12'd4095);
        send_code(12'd0);
        hold_until_drained();
        write_register(cmavg_pkg::CFG_ZERO_CODE, 20'd4095);
        send_code(12'd0);
        send_code(12'd4095);
        hold_until_drained();
        write_register(cmavg_pkg::CFG_SCALE, 20'd0);
        send_code(12'hA5A);
    endtask

    // A length of zero acts as one; lengths past the window size act as the size.
    task automatic test_window_length_edges();
        hold_until_drained();
        write_register(cmavg_pkg::CFG_ZERO_CODE, 20'd2048);
        write_register(cmavg_pkg::CFG_SCALE, 20'd80019);
        write_register(cmavg_pkg::CFG_WIN_LEN, 20'd0);
        send_code(12'd4095);
        send_code(12'd0);
        hold_until_drained();
        write_register(cmavg_pkg::CFG_WIN_LEN, 20'd63);
        send_code(12'd3000);
        send_code(12'd1000);
    endtask

    // One deci-amp per code with a one-entry window, so every trip and release
    // level can be hit exactly, just inside and just outside.
    task automatic test_comparator_hysteresis();
        hold_until_drained();
        write_register(cmavg_pkg::CFG_WIN_LEN, 20'd1);
        write_register(cmavg_pkg::CFG_SCALE, 20'd65536);
        write_register(cmavg_pkg::CFG_OVER, {4'd0, 16'(100)});
        write_register(cmavg_pkg::CFG_REVERSE, {4'd0, 16'(-100)});
        write_register(cmavg_pkg::CFG_HYST, 20'd20);
        send_code(12'd2147);
        send_code(12'd2148);
        send_code(12'd2129);
        send_code(12'd2128);
        send_code(12'd1949);
        send_code(12'd1948);
        send_code(12'd1967);
        send_code(12'd1968);
    endtask

    // A length write empties the window but keeps the level, which then holds
    // until the window has filled again.
    task automatic test_held_level_while_filling();
        hold_until_drained();
        send_code(12'd2300);
        hold_until_drained();
        write_register(cmavg_pkg::CFG_WIN_LEN, 20'd3);
        repeat (3) send_code(12'd1000);
    endtask

    // Settings for one random phase: mostly values that make the level move,
    // with the register extremes mixed in.
    task automatic pick_random_settings();
        int zero;
        int scale;
        int len;
        int over;
        int rev;
        int band;
        case ($urandom_range(0, 5))
            0: zero = 0;
            1: zero = 4095;
            default: zero = $urandom_range(1200, 2900);
        endcase
        case ($urandom_range(0, 7))
            0: scale = 0;
            1: scale = 1048575;
            2: scale = $urandom_range(0, 1048575);
            default: scale = $urandom_range(20000, 140000);
        endcase
        case ($urandom_range(0, 9))
            0: len = 0;
            1: len = 32;
            2: len = 33;
            3: len = 63;
            4: len = 1;
            default: len = $urandom_range(2, 8);
        endcase
        case ($urandom_range(0, 7))
            0: over = 32767;
            1: over = -32768;
            default: over = int'($urandom_range(0, 3000)) - 500;
        endcase
        case ($urandom_range(0, 7))
            0: rev = -32768;
            1: rev = 32767;
            default: rev = 500 - int'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 7))
            0: band = 0;
            1: band = 32767;
            default: band = $urandom_range(0, 400);
        endcase
        write_register(cmavg_pkg::CFG_ZERO_CODE, CFG_DATA_W'(zero));
        write_register(cmavg_pkg::CFG_SCALE, CFG_DATA_W'(scale));
        // Now and then the window is carried over into the new phase.
        if ($urandom_range(0, 3) != 0) begin
            write_register(cmavg_pkg::CFG_WIN_LEN, CFG_DATA_W'(len));
        end
        write_register(cmavg_pkg::CFG_OVER, {4'd0, 16'(over)});
        write_register(cmavg_pkg::CFG_REVERSE, {4'd0, 16'(rev)});
        write_register(cmavg_pkg::CFG_HYST, CFG_DATA_W'(band));
    endtask

    // Random phases: codes follow a slow random walk so the average drifts
    // across the limits, with scattered codes anywhere in range as noise.
    task automatic test_random_traffic();
        int count;
        int walk;
        int code;
        while (items_sent < ITEM_TARGET) begin
            hold_until_drained();
            pick_random_settings();
            gaps_enabled = ($urandom_range(0, 3) != 0);
            phases_run++;
            walk  = $urandom_range(0, 4095);
            count = $urandom_range(30, 90);
            repeat (count) begin
                if ($urandom_range(0, 9) == 0) begin
                    code = $urandom_range(0, 4095);
                end else begin
                    walk += int'($urandom_range(0, 400)) - 200;
                    walk  = (walk < 0) ? 0 : ((walk > 4095) ? 4095 : walk);
                    code  = walk;
                end
                send_code(CODE_W'(code));
            end
        end
        gaps_enabled = 1'b1;
    endtask

    // Result side: a random stall before each result while gaps are enabled, then a
    // field-by-field comparison with the oldest expectation.
    initial begin : result_checker
        t_reading want;
        int       stall;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = gaps_enabled ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            do @(posedge i_clk); while (o_res_valid !== 1'b1);
            if (pending_readings.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = pending_readings.pop_front();
                if (want.changed) begin
                    level_changes++;
                end
                if (o_sample_current !== want.sample) begin
                    report_mismatch("sample_current", o_sample_current, want.sample);
                end
                if (o_average_current !== want.average) begin
                    report_mismatch("average_current", o_average_current, want.average);
                end
                if (o_window_ready !== want.full) begin
                    report_mismatch("window_ready", o_window_ready, want.full);
                end
                if (o_level_state !== want.level) begin
                    report_mismatch("level_state", o_level_state, want.level);
                end
                if (o_state_changed !== want.changed) begin
                    report_mismatch("state_changed", o_state_changed, want.changed);
                end
                results_checked++;
            end
        end
    end

    // Any cycle with a register write or an accepted request on either side
    // counts as progress; a long run of cycles without one is a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_adc_valid && o_adc_ready)
                || (o_res_valid && i_res_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_readings.size());
            $display("** current_monitor_avg_hysteresis: FAILED **");
            $finish;
        end
    end

    initial begin
        cfg_zero    = 12'd2048;
        cfg_scale   = 20'd80019;
        cfg_len     = 6'd32;
        cfg_over    = 16'sd1500;
        cfg_reverse = -16'sd1500;
        cfg_band    = 15'd50;
        cur_level   = cmavg_pkg::LVL_NORMAL;
        clear_window_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_conversion_extremes();
        test_window_length_edges();
        test_comparator_hysteresis();
        test_held_level_while_filling();
        test_random_traffic();

        // Let the last results come back, then give a stray result time to show.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d codes: directed conversion, length and hysteresis checks,",
                 items_sent);
        $display("then %0d random phases; compared %0d results, %0d with a level change.",
                 phases_run, results_checked, level_changes);
        if (mismatch_count == 0) begin
            $display("** current_monitor_avg_hysteresis: PASSED **");
        end else begin
            $display("%0d mismatches.", mismatch_count);
            $display("** current_monitor_avg_hysteresis: FAILED **");
        end
        $finish;
    end

endmodule

[current_monitor_avg_hysteresis.f]
design/cmavg_pkg.sv
design/cmavg_ram.sv
design/cmavg_front.sv
design/cmavg_fifo.sv
design/cmavg_back.sv
design/current_monitor_avg_hysteresis.sv
verif/tb_current_monitor_avg_hysteresis.sv
